// File: rtl/core/power_cap_thread_governor_core_macros.svh
// assertion helpers used by the checker file
`ifndef POWER_CAP_THREAD_GOVERNOR_CORE_MACROS_SVH
`define POWER_CAP_THREAD_GOVERNOR_CORE_MACROS_SVH

// clocked property with active-low reset masking
`define PCGOV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same-cycle implication built on the generic form
`define PCGOV_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    `PCGOV_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// File: rtl/core/pcgov_pkg.sv
package pcgov_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CAP_W      = 10;
    localparam int FRAC_SHIFT = 8;
    localparam int AVG_W      = SAMPLE_W + 12;
    localparam int WIN_W      = 5;
    localparam int PROD_W     = AVG_W + WIN_W + 1;
    localparam int DCNT_W     = $clog2(PROD_W + 1);
    localparam int IDX_W      = 3;
    localparam int CFG_W      = SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] RST_HIGH_LIMIT = SAMPLE_W'(3200);
    localparam logic [SAMPLE_W-1:0] RST_LOW_LIMIT  = SAMPLE_W'(1600);
    localparam logic [CAP_W-1:0]    RST_MAX_THR    = CAP_W'(64);
    localparam logic [CAP_W-1:0]    RST_MIN_THR    = CAP_W'(1);
    localparam logic [WIN_W-1:0]    RST_WINDOW     = WIN_W'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_HIGH_LIMIT = 3'd0,
        REG_LOW_LIMIT  = 3'd1,
        REG_MAX_THR    = 3'd2,
        REG_MIN_THR    = 3'd3,
        REG_WINDOW     = 3'd4,
        REG_FROZEN     = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_LOWER = 2'd1,
        ACT_RAISE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_limit;
        logic [SAMPLE_W-1:0] low_limit;
        logic [CAP_W-1:0]    ceil_threads;
        logic [CAP_W-1:0]    floor_threads;
        logic [WIN_W-1:0]    hold_reload;
    } pol_cfg_t;

endpackage

// File: rtl/core/pcgov_divider.sv
module pcgov_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pcgov_pkg::PROD_W-1:0]      dividend,
    input  logic [pcgov_pkg::WIN_W-1:0]       divisor,
    output logic [pcgov_pkg::PROD_W-1:0]      quotient,
    output pcgov_pkg::div_stat_t              stat
);

    logic [pcgov_pkg::PROD_W-1:0] work_reg;
    logic [pcgov_pkg::WIN_W-1:0]  rem_reg;
    logic [pcgov_pkg::DCNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [pcgov_pkg::WIN_W:0]    shifted;
    logic [pcgov_pkg::WIN_W:0]    trial;
    logic                         fits;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_comb begin
        shifted = {rem_reg, work_reg[pcgov_pkg::PROD_W-1]};
        fits    = shifted >= {1'b0, divisor};
        trial   = shifted - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pcgov_pkg::DCNT_W'(pcgov_pkg::PROD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pcgov_pkg::DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            work_reg <= {work_reg[pcgov_pkg::PROD_W-2:0], fits};
            rem_reg  <= fits ? trial[pcgov_pkg::WIN_W-1:0] : shifted[pcgov_pkg::WIN_W-1:0];
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/pcgov_policy.sv
module pcgov_policy (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pcgov_pkg::pol_cfg_t               cfg,
    input  logic                              max_load,
    input  logic [pcgov_pkg::CAP_W-1:0]       max_value,
    input  logic                              commit,
    input  logic [pcgov_pkg::SAMPLE_W-1:0]    sample,
    input  logic [pcgov_pkg::AVG_W-1:0]       avg,
    output logic [pcgov_pkg::CAP_W-1:0]       cap,
    output logic                              throttle,
    output pcgov_pkg::action_t                action
);

    logic [pcgov_pkg::WIN_W-1:0]  hold_reg;
    logic [pcgov_pkg::CAP_W-1:0]  cap_reg;
    logic                         flag_reg;

    logic                         nonzero;
    logic [pcgov_pkg::WIN_W-1:0]  hold_dec;
    logic [pcgov_pkg::AVG_W-1:0]  hi_scaled;
    logic [pcgov_pkg::AVG_W-1:0]  lo_scaled;
    logic                         hot;
    logic                         cold;
    logic [pcgov_pkg::CAP_W-1:0]  diff;
    logic [pcgov_pkg::CAP_W:0]    min_plus1;
    logic [pcgov_pkg::CAP_W-1:0]  cap_lower;
    logic [pcgov_pkg::CAP_W:0]    sum2;
    logic [pcgov_pkg::CAP_W-1:0]  cap_raise;

    always_comb begin
        nonzero   = sample != '0;
        hold_dec  = (hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;
        hi_scaled = pcgov_pkg::AVG_W'(cfg.high_limit) << pcgov_pkg::FRAC_SHIFT;
        lo_scaled = pcgov_pkg::AVG_W'(cfg.low_limit) << pcgov_pkg::FRAC_SHIFT;
        hot       = (hold_dec == '0) && (sample > cfg.high_limit) && (avg > hi_scaled);
        cold      = (hold_dec == '0) && (sample < cfg.low_limit) && (avg < lo_scaled);

        // halfway toward the minimum, at least one step, never below the minimum
        diff      = cap_reg - cfg.floor_threads;
        min_plus1 = {1'b0, cfg.floor_threads} + 1'b1;
        cap_lower = ({1'b0, cap_reg} > min_plus1) ? cap_reg - (diff >> 1) : cfg.floor_threads;

        sum2      = {1'b0, cap_reg} + 2'd2;
        cap_raise = (sum2 > {1'b0, cfg.ceil_threads}) ? cfg.ceil_threads
                                                      : sum2[pcgov_pkg::CAP_W-1:0];

        if (!nonzero) begin
            action = pcgov_pkg::ACT_NONE;
        end else if (hot) begin
            action = pcgov_pkg::ACT_LOWER;
        end else if (cold) begin
            action = pcgov_pkg::ACT_RAISE;
        end else begin
            action = pcgov_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
            cap_reg  <= pcgov_pkg::RST_MAX_THR;
            flag_reg <= 1'b1;
        end else if (max_load) begin
            cap_reg <= max_value;
        end else if (commit && nonzero) begin
            case (action)
                pcgov_pkg::ACT_LOWER: begin
                    cap_reg  <= cap_lower;
                    flag_reg <= 1'b1;
                    hold_reg <= cfg.hold_reload;
                end
                pcgov_pkg::ACT_RAISE: begin
                    cap_reg  <= cap_raise;
                    flag_reg <= 1'b0;
                    hold_reg <= cfg.hold_reload;
                end
                default: begin
                    hold_reg <= hold_dec;
                end
            endcase
        end
    end

    assign cap      = cap_reg;
    assign throttle = flag_reg;

endmodule

// File: rtl/core/power_cap_thread_governor_core.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | s_valid / s_ready  | s_power_sample (Q12.4 watts)
// result    | m_valid / m_ready  | m_cap_now, m_throttling, m_action_taken
// config    | cfg_wr_en          | cfg_addr, cfg_wdata (write only, no wait)
//
// a normal item passes through the multiply state, the 34-step serial divider that
// forms the moving average (one quotient bit a cycle), the decide state and the output
// state; a frozen item skips the arithmetic and goes from idle straight to the output state
// s_ready is high only while the sequencer is idle, one item at a time
// the result sits in an output register, so a stalled m_ready holds the next
// item only when that item is finished and the register is still full
// aresetn is synchronous, active low, and restores all limits and the cap

module power_cap_thread_governor_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pcgov_pkg::SAMPLE_W-1:0]       s_power_sample,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pcgov_pkg::CAP_W-1:0]          m_cap_now,
    output logic                                 m_throttling,
    output logic [1:0]                           m_action_taken,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [pcgov_pkg::IDX_W-1:0]          cfg_addr,
    input  logic [pcgov_pkg::CFG_W-1:0]          cfg_wdata
);

    // configuration registers
    logic [pcgov_pkg::SAMPLE_W-1:0] high_reg;
    logic [pcgov_pkg::SAMPLE_W-1:0] low_reg;
    logic [pcgov_pkg::CAP_W-1:0]    maxt_reg;
    logic [pcgov_pkg::CAP_W-1:0]    mint_reg;
    logic [pcgov_pkg::WIN_W-1:0]    win_reg;
    logic                           frozen_reg;

    // sequencer and datapath registers
    pcgov_pkg::state_t              state_reg;
    pcgov_pkg::state_t              state_next;
    logic [pcgov_pkg::SAMPLE_W-1:0] sample_reg;
    logic [pcgov_pkg::AVG_W-1:0]    avg_reg;
    pcgov_pkg::action_t             act_reg;

    // output register
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [pcgov_pkg::CAP_W-1:0]    cap_out_reg;
    logic                           thr_out_reg;
    pcgov_pkg::action_t             act_out_reg;

    // sequencer controls
    logic                           accept;
    logic                           div_start;
    logic                           avg_load;
    logic                           commit;
    logic                           out_load;

    // arithmetic
    logic [pcgov_pkg::WIN_W-1:0]         w_eff;
    logic [pcgov_pkg::WIN_W-1:0]         w_m1;
    logic [pcgov_pkg::AVG_W+pcgov_pkg::WIN_W-1:0] prod;
    logic [pcgov_pkg::PROD_W-1:0]        dividend;
    logic [pcgov_pkg::PROD_W-1:0]        quotient;
    pcgov_pkg::div_stat_t                div_stat;

    pcgov_pkg::pol_cfg_t                 pol_cfg;
    logic                                max_load;
    logic [pcgov_pkg::CAP_W-1:0]         cap_cur;
    logic                                thr_cur;
    pcgov_pkg::action_t                  pol_action;

    // ---------------- configuration ----------------

    // a window of zero behaves as a window of one
    assign w_eff    = (win_reg == '0) ? pcgov_pkg::WIN_W'(1) : win_reg;
    assign w_m1     = w_eff - 1'b1;
    assign max_load = cfg_wr_en && (cfg_addr == pcgov_pkg::REG_MAX_THR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg   <= pcgov_pkg::RST_HIGH_LIMIT;
            low_reg    <= pcgov_pkg::RST_LOW_LIMIT;
            maxt_reg   <= pcgov_pkg::RST_MAX_THR;
            mint_reg   <= pcgov_pkg::RST_MIN_THR;
            win_reg    <= pcgov_pkg::RST_WINDOW;
            frozen_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pcgov_pkg::REG_HIGH_LIMIT: high_reg   <= cfg_wdata[pcgov_pkg::SAMPLE_W-1:0];
                pcgov_pkg::REG_LOW_LIMIT:  low_reg    <= cfg_wdata[pcgov_pkg::SAMPLE_W-1:0];
                pcgov_pkg::REG_MAX_THR:    maxt_reg   <= cfg_wdata[pcgov_pkg::CAP_W-1:0];
                pcgov_pkg::REG_MIN_THR:    mint_reg   <= cfg_wdata[pcgov_pkg::CAP_W-1:0];
                pcgov_pkg::REG_WINDOW:     win_reg    <= cfg_wdata[pcgov_pkg::WIN_W-1:0];
                pcgov_pkg::REG_FROZEN:     frozen_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcgov_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        avg_load   = 1'b0;
        commit     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            pcgov_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // frozen: nothing moves, the result reports the current cap
                    state_next = frozen_reg ? pcgov_pkg::ST_OUT : pcgov_pkg::ST_MUL;
                end
            end
            pcgov_pkg::ST_MUL: begin
                div_start  = 1'b1;
                state_next = pcgov_pkg::ST_DIV;
            end
            pcgov_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    avg_load   = 1'b1;
                    state_next = pcgov_pkg::ST_DECIDE;
                end
            end
            pcgov_pkg::ST_DECIDE: begin
                commit     = 1'b1;
                state_next = pcgov_pkg::ST_OUT;
            end
            pcgov_pkg::ST_OUT: begin
                // wait for room in the output register
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pcgov_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcgov_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------- datapath ----------------

    // avg*(W-1) + sample<<8, then divided by W in the serial divider
    assign prod     = (pcgov_pkg::AVG_W + pcgov_pkg::WIN_W)'(avg_reg)
                    * (pcgov_pkg::AVG_W + pcgov_pkg::WIN_W)'(w_m1);
    assign dividend = pcgov_pkg::PROD_W'(prod)
                    + (pcgov_pkg::PROD_W'(sample_reg) << pcgov_pkg::FRAC_SHIFT);

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_power_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
            act_reg <= pcgov_pkg::ACT_NONE;
        end else begin
            if (avg_load) begin
                avg_reg <= quotient[pcgov_pkg::AVG_W-1:0];
            end
            if (accept) begin
                act_reg <= pcgov_pkg::ACT_NONE;
            end else if (commit) begin
                act_reg <= pol_action;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            cap_out_reg <= cap_cur;
            thr_out_reg <= thr_cur;
            act_out_reg <= act_reg;
        end
    end

    pcgov_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (w_eff),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        pol_cfg.high_limit    = high_reg;
        pol_cfg.low_limit     = low_reg;
        pol_cfg.ceil_threads  = maxt_reg;
        pol_cfg.floor_threads = mint_reg;
        pol_cfg.hold_reload   = w_eff;
    end

    pcgov_policy u_pol (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (pol_cfg),
        .max_load  (max_load),
        .max_value (cfg_wdata[pcgov_pkg::CAP_W-1:0]),
        .commit    (commit),
        .sample    (sample_reg),
        .avg       (avg_reg),
        .cap       (cap_cur),
        .throttle  (thr_cur),
        .action    (pol_action)
    );

    assign m_valid        = m_valid_reg;
    assign m_cap_now      = cap_out_reg;
    assign m_throttling   = thr_out_reg;
    assign m_action_taken = act_out_reg;

endmodule

// File: rtl/core/pcgov_checker.sv
`include "power_cap_thread_governor_core_macros.svh"

module pcgov_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [pcgov_pkg::CAP_W-1:0]    m_cap_now,
    input logic                           m_throttling,
    input logic [1:0]                     m_action_taken
);

    // a stalled result keeps its payload
    `PCGOV_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_cap_now) && $stable(m_throttling) && $stable(m_action_taken)), "result changed while stalled")

    // one item at a time: busy right after an accept
    `PCGOV_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready stayed high after accept")

    // lowering always turns throttling on
    `PCGOV_IMPLY(a_lower_throttles, aclk, aresetn, m_valid && (m_action_taken == pcgov_pkg::ACT_LOWER), m_throttling, "lowered cap without throttling")

    // raising always turns throttling off
    `PCGOV_IMPLY(a_raise_releases, aclk, aresetn, m_valid && (m_action_taken == pcgov_pkg::ACT_RAISE), !m_throttling, "raised cap while throttling")

    // no undefined action code reaches the port
    `PCGOV_IMPLY(a_action_code, aclk, aresetn, m_valid, m_action_taken != 2'd3, "bad action code")

endmodule

bind power_cap_thread_governor_core pcgov_checker u_pcgov_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_cap_now      (m_cap_now),
    .m_throttling   (m_throttling),
    .m_action_taken (m_action_taken)
);

// File: bench/power_cap_thread_governor_core_tb.sv
`timescale 1ns / 1ps

module power_cap_thread_governor_core_tb;
    import pcgov_pkg::*;

    // stop rule for the random part, counted in samples the governor acts on
    localparam int RANDOM_SAMPLES = 1000;
    // cycles with no item moving on either channel before the run is called hung
    localparam int IDLE_LIMIT     = 1000;
    // settle time after the last result, a bit above the divider latency
    localparam int TAIL_CYCLES    = 48;
    // index past the last register, writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic [CAP_W-1:0] cap;
        logic             thr;
        action_t          act;
    } gov_result_t;

    // one row of the directed table: either a register write or a sample
    typedef struct packed {
        logic             is_write;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] value;
        logic             typed;
        gov_result_t      res;
    } plan_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_power_sample;
    logic                m_valid;
    logic                m_ready;
    logic [CAP_W-1:0]    m_cap_now;
    logic                m_throttling;
    logic [1:0]          m_action_taken;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    // governor model: registers
    logic [SAMPLE_W-1:0] lim_high;
    logic [SAMPLE_W-1:0] lim_low;
    logic [CAP_W-1:0]    thr_max;
    logic [CAP_W-1:0]    thr_min;
    logic [WIN_W-1:0]    win_len;
    logic                freeze;

    // governor model: state
    logic [AVG_W-1:0]    avg_q;
    logic [WIN_W-1:0]    hold_cnt;
    logic [CAP_W-1:0]    cap_cur;
    logic                thr_on;

    gov_result_t         cap_exp_q[$];
    gov_result_t         cap_head;
    plan_row_t           plan_q[$];

    bit                  no_idle;
    bit                  trend_hot;
    int                  trend_left;
    int                  fail_count;
    int                  results_seen;
    int                  lowered;
    int                  raised;
    int                  idle_cycles;

    power_cap_thread_governor_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_power_sample (s_power_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cap_now      (m_cap_now),
        .m_throttling   (m_throttling),
        .m_action_taken (m_action_taken),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // governor model
    // ------------------------------------------------------------------

    // register write as the block sees it; unknown indexes fall through
    function automatic void apply_write(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] value);
        case (idx)
            REG_HIGH_LIMIT: lim_high = value;
            REG_LOW_LIMIT:  lim_low  = value;
            REG_MAX_THR: begin
                // the max write also reloads the cap
                thr_max = value[CAP_W-1:0];
                cap_cur = value[CAP_W-1:0];
            end
            REG_MIN_THR:    thr_min  = value[CAP_W-1:0];
            REG_WINDOW:     win_len  = value[WIN_W-1:0];
            REG_FROZEN:     freeze   = value[0];
            default: ;
        endcase
    endfunction

    // one sample through the policy, returns the result the block must show
    function automatic gov_result_t apply_sample(input logic [SAMPLE_W-1:0] sample);
        logic [63:0] w;
        logic [63:0] acc;
        longint      diff;
        longint      step;
        longint      next_cap;
        gov_result_t res;
        res.act = ACT_NONE;
        if (!freeze) begin
            // window of zero behaves as one
            w     = (win_len == '0) ? 64'd1 : 64'(win_len);
            // moving average in Q12.12, truncating divide; zero samples count too
            acc   = 64'(avg_q) * (w - 64'd1) + (64'(sample) << FRAC_SHIFT);
            avg_q = AVG_W'(acc / w);
            if (sample != '0) begin
                if (hold_cnt != '0) hold_cnt = hold_cnt - 1'b1;
                if (hold_cnt == '0 && sample > lim_high &&
                    64'(avg_q) > (64'(lim_high) << FRAC_SHIFT)) begin
                    // halfway toward the floor, at least one thread,
                    // and never below the floor (even if that is above max)
                    diff = longint'(cap_cur) - longint'(thr_min);
                    step = (diff >= 0) ? diff / 2 : 0;
                    if (step <= 0) step = 1;
                    next_cap = longint'(cap_cur) - step;
                    if (next_cap < longint'(thr_min)) next_cap = longint'(thr_min);
                    cap_cur  = CAP_W'(next_cap);
                    thr_on   = 1'b1;
                    hold_cnt = WIN_W'(w);
                    res.act  = ACT_LOWER;
                end else if (hold_cnt == '0 && sample < lim_low &&
                             64'(avg_q) < (64'(lim_low) << FRAC_SHIFT)) begin
                    // up by two, clamped at max, which also pulls an oversized cap down
                    next_cap = longint'(cap_cur) + 2;
                    if (next_cap > longint'(thr_max)) next_cap = longint'(thr_max);
                    cap_cur  = CAP_W'(next_cap);
                    thr_on   = 1'b0;
                    hold_cnt = WIN_W'(w);
                    res.act  = ACT_RAISE;
                end
            end
        end
        res.cap = cap_cur;
        res.thr = thr_on;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // per-item wait on either side, zero in the no-idle stretches
    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic void add_write(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
        plan_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.value    = value;
        plan_q.push_back(row);
    endfunction

    function automatic void add_item(input logic [SAMPLE_W-1:0] value,
                                     input logic typed = 1'b0,
                                     input logic [CAP_W-1:0] cap = '0,
                                     input logic thr = 1'b0,
                                     input action_t act = ACT_NONE);
        plan_row_t row;
        row         = '0;
        row.value   = value;
        row.typed   = typed;
        row.res.cap = cap;
        row.res.thr = thr;
        row.res.act = act;
        plan_q.push_back(row);
    endfunction

    // samples mostly come in hot or cool runs so the average follows them
    // past the limits; the rest are gaps, limit edges and full-range noise
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned roll;
        if (trend_left == 0) begin
            trend_hot  = $urandom_range(0, 1);
            trend_left = $urandom_range(2, 24);
        end
        trend_left--;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 16) return SAMPLE_W'($urandom);
        if (roll < 22) begin
            case ($urandom_range(0, 3))
                0:       return lim_high;
                1:       return lim_high + 1'b1;
                2:       return lim_low;
                default: return lim_low - 1'b1;
            endcase
        end
        if (trend_hot)
            return (lim_high == '1) ? '1
                 : SAMPLE_W'($urandom_range(32'(lim_high) + 1, 65535));
        return (lim_low <= 1) ? SAMPLE_W'(1)
             : SAMPLE_W'($urandom_range(1, 32'(lim_low) - 1));
    endfunction

    // lower valid and wait until every issued sample has its result back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (cap_exp_q.size() != 0) @(posedge aclk);
    endtask

    // one-cycle write pulse, then enable is held low before returning, so back-to-back writes never collide
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        apply_write(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one sample, record its expected result at the accepting edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input gov_result_t typed_res);
        int          gap;
        gov_result_t want;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_power_sample <= value;
        do @(posedge aclk); while (!s_ready);
        want = apply_sample(value);
        cap_exp_q.push_back(typed ? typed_res : want);
    endtask

    // random policy for one phase: limits, thread range, window, freeze
    task automatic pick_policy();
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [CAP_W-1:0]    mx;
        logic [CAP_W-1:0]    mn;
        case ($urandom_range(0, 7))
            0: begin
                // neither limit can ever trip
                lo = '0;
                hi = '1;
            end
            1: begin
                // every nonzero sample is outside the band
                lo = '1;
                hi = '0;
            end
            default: begin
                lo = SAMPLE_W'($urandom_range(1, 30000));
                hi = lo + SAMPLE_W'($urandom_range(0, 30000));
            end
        endcase
        case ($urandom_range(0, 5))
            0:       mx = CAP_W'(1);
            1:       mx = '1;
            default: mx = CAP_W'($urandom_range(1, 1023));
        endcase
        // now and then a floor above the ceiling
        mn = ($urandom_range(0, 7) == 0) ? CAP_W'($urandom_range(1, 1023))
                                          : CAP_W'($urandom_range(1, mx));
        write_reg(REG_HIGH_LIMIT, hi);
        write_reg(REG_LOW_LIMIT, lo);
        write_reg(REG_MIN_THR, CFG_W'(mn));
        write_reg(REG_WINDOW, CFG_W'($urandom_range(1, 16)));
        // leave the cap running across phases about half the time
        if ($urandom_range(0, 1) == 0) write_reg(REG_MAX_THR, CFG_W'(mx));
        write_reg(REG_FROZEN, ($urandom_range(0, 9) == 0) ? CFG_W'(1) : CFG_W'(0));
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls on m_ready
    // ------------------------------------------------------------------
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // result checker: in order, field by field
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cap_exp_q.size() == 0) begin
                $error("result with no sample outstanding: cap_now %0d", m_cap_now);
                fail_count++;
            end else begin
                cap_head = cap_exp_q.pop_front();
                if (m_cap_now !== cap_head.cap) begin
                    $error("cap_now: expected %0d, actual %0d", cap_head.cap, m_cap_now);
                    fail_count++;
                end
                if (m_throttling !== cap_head.thr) begin
                    $error("throttling: expected %0d, actual %0d", cap_head.thr, m_throttling);
                    fail_count++;
                end
                if (m_action_taken !== cap_head.act) begin
                    $error("action_taken: expected %0d, actual %0d",
                           cap_head.act, m_action_taken);
                    fail_count++;
                end
                results_seen++;
                if (cap_head.act == ACT_LOWER) lowered++;
                else if (cap_head.act == ACT_RAISE) raised++;
            end
        end
    end

    // hang detector: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, cap_exp_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int counted;
        int phases;
        int n_items;
        int frozen_sent;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_power_sample = '0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        trend_left     = 0;
        counted        = 0;
        phases         = 0;
        frozen_sent    = 0;

        // model in its reset state
        lim_high = RST_HIGH_LIMIT;
        lim_low  = RST_LOW_LIMIT;
        thr_max  = RST_MAX_THR;
        thr_min  = RST_MIN_THR;
        win_len  = RST_WINDOW;
        freeze   = 1'b0;
        avg_q    = '0;
        hold_cnt = '0;
        cap_cur  = RST_MAX_THR;
        thr_on   = 1'b1;

        // directed table, reset policy first
        // a zero sample right after reset: nothing moves
        add_item(16'h0000, 1'b1, CAP_W'(64), 1'b1, ACT_NONE);
        // full-scale sample: cap 64 drops by (64-1)/2 to 33
        add_item(16'hFFFF, 1'b1, CAP_W'(33), 1'b1, ACT_LOWER);
        // same again, but the hold-off blocks it
        add_item(16'hFFFF, 1'b1, CAP_W'(33), 1'b1, ACT_NONE);
        // sample exactly at, then just over, the high limit
        add_item(16'd3200);
        add_item(16'd3201);
        add_item(16'h5555);
        add_item(16'hAAAA);
        // exactly at, then just under, the low limit
        add_item(16'd1600);
        add_item(16'd1599);
        add_item(16'h0001);
        add_item(16'h0001);
        add_item(16'h0001);
        // shortest window: average tracks the sample, hold-off of one
        add_write(REG_WINDOW, CFG_W'(1));
        add_item(16'h0001);
        add_item(16'h0001);
        // index past the register file is dropped
        add_write(REG_UNUSED, CFG_W'(5));
        // floor above ceiling: lowering lands on the floor, raising pulls to max
        add_write(REG_MIN_THR, CFG_W'(200));
        add_write(REG_MAX_THR, CFG_W'(50));
        add_item(16'hFFFF);
        add_item(16'h0001);
        // frozen: samples pass through untouched
        add_write(REG_FROZEN, CFG_W'(1));
        add_item(16'hFFFF);
        add_item(16'h0000);
        add_write(REG_FROZEN, CFG_W'(0));
        // window of 16, widest thread range, limits at the rails
        add_write(REG_WINDOW, CFG_W'(16));
        add_write(REG_HIGH_LIMIT, CFG_W'(0));
        add_write(REG_LOW_LIMIT, CFG_W'(16'hFFFF));
        add_write(REG_MAX_THR, CFG_W'(1023));
        add_write(REG_MIN_THR, CFG_W'(1));
        add_item(16'hFFFF);
        add_item(16'h0001);
        add_item(16'hFFFF);

        // synchronous reset
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the directed table; writes only once the block has gone quiet
        foreach (plan_q[i]) begin
            if (plan_q[i].is_write) begin
                wait_drained();
                write_reg(plan_q[i].idx, plan_q[i].value);
            end else begin
                send_sample(plan_q[i].value, plan_q[i].typed, plan_q[i].res);
            end
        end

        // random phases, each under a fresh policy
        while (counted < RANDOM_SAMPLES) begin
            wait_drained();
            pick_policy();
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = freeze ? $urandom_range(5, 20) : $urandom_range(40, 120);
            repeat (n_items) begin
                send_sample(pick_sample(), 1'b0, '0);
                if (freeze) frozen_sent++;
                else counted++;
            end
            phases++;
        end

        // let the last results out, then watch for strays
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("checked %0d results: directed table plus %0d random policy phases",
                 results_seen, phases);
        $display("cap lowered %0d times, raised %0d times, %0d samples sent while frozen",
                 lowered, raised, frozen_sent);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
